// ===== src/wtle_pkg.sv =====
// Shared types, codes and the character cycle of the wheel text line editor.
// Depends on nothing; every other file of the block takes names from here.
`timescale 1ns / 1ps

package wtle_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int CYCLE_SIZE_DEF = 42;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [20:0] CHAR_BLANK = 21'h20;

  // request codes on the input word
  localparam logic [3:0] REQ_FWD   = 4'd0;
  localparam logic [3:0] REQ_BACK  = 4'd1;
  localparam logic [3:0] REQ_LEFT  = 4'd2;
  localparam logic [3:0] REQ_RIGHT = 4'd3;
  localparam logic [3:0] REQ_BKSP  = 4'd4;
  localparam logic [3:0] REQ_DEL   = 4'd5;
  localparam logic [3:0] REQ_LOAD  = 4'd6;
  localparam logic [3:0] REQ_READ  = 4'd7;
  localparam logic [3:0] REQ_CLEAR = 4'd8;

  // register indexes on the configuration port
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd0;
  localparam logic [1:0] REG_FAST_GAP      = 2'd1;
  localparam logic [1:0] REG_VERY_FAST_GAP = 2'd2;
  localparam logic [1:0] REG_DELETE_GAP    = 2'd3;

  typedef enum logic [3:0] {
    OP_FWD, OP_BACK, OP_LEFT, OP_RIGHT, OP_BKSP, OP_DEL,
    OP_LOAD, OP_READ, OP_CLEAR, OP_NONE
  } op_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] now_tick;
    logic [20:0] load_char;
    logic [5:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        changed;
    logic [5:0]  caret_pos;
    logic [5:0]  line_length;
    logic        composing;
    logic [20:0] read_char;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  max_length;
    logic [15:0] fast_gap;
    logic [15:0] very_fast_gap;
    logic [15:0] delete_gap;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t         op;
    logic [2:0]  mag;
    logic [20:0] load_char;
    logic [5:0]  read_index;
  } work_t;

  // blank, A-Z, 0-9, '-', '_', '.', apostrophe, '&', then blanks
  function automatic logic [20:0] cycle_char(logic [5:0] idx);
    logic [20:0] c;
    c = CHAR_BLANK;
    if (idx >= 6'd1 && idx <= 6'd26) begin
      c = 21'h40 + {15'b0, idx};
    end else if (idx >= 6'd27 && idx <= 6'd36) begin
      c = 21'h30 + {15'b0, idx - 6'd27};
    end else if (idx == 6'd37) begin
      c = 21'h2D;
    end else if (idx == 6'd38) begin
      c = 21'h5F;
    end else if (idx == 6'd39) begin
      c = 21'h2E;
    end else if (idx == 6'd40) begin
      c = 21'h27;
    end else if (idx == 6'd41) begin
      c = 21'h26;
    end
    return c;
  endfunction

endpackage

// ===== src/wheel_text_line_editor.sv =====
// Top level of the wheel text line editor: configuration registers, front,
// queue and back. Uses wtle_pkg, wtle_front, wtle_queue and wtle_back.
`timescale 1ns / 1ps
// Back path: straight to S_DONE when nothing moves (caret moves, loads, clears, refusals,
// throttled or empty deletes, reads past the end); S_RDCAP for a read inside the line;
// S_RD, S_POS, S_STEP for a step on a composed character; S_CLOSE (shift) for a removal;
// S_OPEN (shift), S_BLANK, S_RD, S_POS, S_STEP for a wheel step that opens a character.
// One request at a time in the back, the next once S_DONE loads a result; the queue
// holds two words. Reset: synchronous; registers take defaults, line memory is not cleared.

module wheel_text_line_editor #(
  parameter int LINE_DEPTH = wtle_pkg::LINE_DEPTH_DEF,
  parameter int CYCLE_SIZE = wtle_pkg::CYCLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  wtle_pkg::in_item_t req,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output wtle_pkg::out_item_t rsp,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  wtle_pkg::cfg_t  cfg;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  wtle_pkg::work_t q_in;
  wtle_pkg::work_t q_head;
  logic            cfg_write;

  // Configuration: no wait states, write lands in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length    <= 6'd63;
      cfg.fast_gap      <= 16'd6;
      cfg.very_fast_gap <= 16'd2;
      cfg.delete_gap    <= 16'd20;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        wtle_pkg::REG_MAX_LENGTH:    cfg.max_length    <= pwdata[5:0];
        wtle_pkg::REG_FAST_GAP:      cfg.fast_gap      <= pwdata[15:0];
        wtle_pkg::REG_VERY_FAST_GAP: cfg.very_fast_gap <= pwdata[15:0];
        wtle_pkg::REG_DELETE_GAP:    cfg.delete_gap    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back: the register value, zero above its width.
  always_comb begin
    unique case (paddr[3:2])
      wtle_pkg::REG_MAX_LENGTH:    prdata = {26'b0, cfg.max_length};
      wtle_pkg::REG_FAST_GAP:      prdata = {16'b0, cfg.fast_gap};
      wtle_pkg::REG_VERY_FAST_GAP: prdata = {16'b0, cfg.very_fast_gap};
      wtle_pkg::REG_DELETE_GAP:    prdata = {16'b0, cfg.delete_gap};
      default:                     prdata = '0;
    endcase
  end

  // Front: take the word, stamp wheel and delete times, classify.
  wtle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  // Hold classified words while the back shifts the line.
  wtle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: edit the line memory and present the result word.
  wtle_back #(
    .LINE_DEPTH (LINE_DEPTH),
    .CYCLE_SIZE (CYCLE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== src/wtle_front.sv =====
// Front end: accepts request words, keeps the wheel and delete timestamps,
// classifies each request into an operation. Uses wtle_pkg.
`timescale 1ns / 1ps

module wtle_front (
  input  logic              clk,
  input  logic              rst,
  input  wtle_pkg::cfg_t    cfg,
  input  logic              req_valid,
  output logic              req_stall,
  input  wtle_pkg::in_item_t req,
  input  logic              q_full,
  output logic              push,
  output wtle_pkg::work_t   push_data
);

  logic [31:0] last_wheel;
  logic [31:0] last_delete;
  logic [31:0] dt_wheel;
  logic [31:0] dt_delete;
  logic        del_ok;
  logic [2:0]  mag;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  assign dt_wheel  = req.now_tick - last_wheel;
  assign dt_delete = req.now_tick - last_delete;
  assign del_ok    = dt_delete >= {16'b0, cfg.delete_gap};

  always_comb begin
    priority if (dt_wheel < {16'b0, cfg.very_fast_gap}) begin
      mag = 3'd4;
    end else if (dt_wheel < {16'b0, cfg.fast_gap}) begin
      mag = 3'd2;
    end else begin
      mag = 3'd1;
    end
  end

  always_comb begin
    push_data.mag        = mag;
    push_data.load_char  = req.load_char;
    push_data.read_index = req.read_index;
    unique case (req.req_type)
      wtle_pkg::REQ_FWD:   push_data.op = wtle_pkg::OP_FWD;
      wtle_pkg::REQ_BACK:  push_data.op = wtle_pkg::OP_BACK;
      wtle_pkg::REQ_LEFT:  push_data.op = wtle_pkg::OP_LEFT;
      wtle_pkg::REQ_RIGHT: push_data.op = wtle_pkg::OP_RIGHT;
      wtle_pkg::REQ_BKSP:  push_data.op = del_ok ? wtle_pkg::OP_BKSP : wtle_pkg::OP_NONE;
      wtle_pkg::REQ_DEL:   push_data.op = del_ok ? wtle_pkg::OP_DEL : wtle_pkg::OP_NONE;
      wtle_pkg::REQ_LOAD:  push_data.op = wtle_pkg::OP_LOAD;
      wtle_pkg::REQ_READ:  push_data.op = wtle_pkg::OP_READ;
      wtle_pkg::REQ_CLEAR: push_data.op = wtle_pkg::OP_CLEAR;
      default:             push_data.op = wtle_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_wheel  <= '0;
      last_delete <= '0;
    end else if (push) begin
      unique case (req.req_type)
        wtle_pkg::REQ_FWD, wtle_pkg::REQ_BACK: begin
          last_wheel <= req.now_tick;
        end
        wtle_pkg::REQ_BKSP, wtle_pkg::REQ_DEL: begin
          if (del_ok) last_delete <= req.now_tick;
        end
        wtle_pkg::REQ_CLEAR: begin
          last_wheel  <= req.now_tick;
          last_delete <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/wtle_queue.sv =====
// Short queue of classified requests between front and back.
// Uses wtle_pkg for the entry type and depth.
`timescale 1ns / 1ps

module wtle_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wtle_pkg::work_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output wtle_pkg::work_t head
);

  localparam int PW = (wtle_pkg::QUEUE_DEPTH > 1) ? $clog2(wtle_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(wtle_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(wtle_pkg::QUEUE_DEPTH - 1);

  wtle_pkg::work_t slots [wtle_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = count == CW'(wtle_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/wtle_back.sv =====
// Back end: line buffer memory, caret and composing state, shift sequencer
// and result register. Uses wtle_pkg.
`timescale 1ns / 1ps

module wtle_back #(
  parameter int LINE_DEPTH = wtle_pkg::LINE_DEPTH_DEF,
  parameter int CYCLE_SIZE = wtle_pkg::CYCLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  wtle_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  wtle_pkg::work_t    head,
  output logic               pop,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output wtle_pkg::out_item_t rsp
);

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int CAP = (LINE_DEPTH - 1 < 63) ? LINE_DEPTH - 1 : 63;
  localparam logic [5:0] CAP6 = 6'(CAP);
  localparam logic [8:0] CS9  = 9'(CYCLE_SIZE);
  localparam logic [8:0] CS4  = 9'(4 * CYCLE_SIZE);

  typedef enum logic [3:0] {
    S_IDLE, S_OPEN, S_BLANK, S_RD, S_POS, S_STEP, S_CLOSE, S_RDCAP, S_DONE
  } state_t;

  state_t          state;
  logic [5:0]      length;
  logic [5:0]      caret;
  logic            comp;
  logic [5:0]      rp;
  logic [5:0]      wa;
  logic            pend;
  wtle_pkg::work_t cur;
  logic [5:0]      pos;
  logic            chg;
  logic [20:0]     rchar;
  logic            rsp_load;

  logic [20:0]     mem [LINE_DEPTH];
  logic [20:0]     rd_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [20:0]     mem_wdata;

  logic [5:0]      lim_raw;
  logic [5:0]      limit;

  function automatic logic [AW-1:0] to_addr(logic [5:0] p);
    logic [AW+5:0] w;
    w = {{AW{1'b0}}, p};
    return w[AW-1:0];
  endfunction

  // first cycle entry holding ch; a character outside the cycle maps to entry 0
  function automatic logic [5:0] cycle_pos(logic [20:0] ch);
    logic [5:0] p;
    p = '0;
    for (int i = CYCLE_SIZE - 1; i >= 0; i--) begin
      if (wtle_pkg::cycle_char(6'(i)) == ch) p = 6'(i);
    end
    return p;
  endfunction

  // advance by m entries, wrapping; the sum stays below five times CYCLE_SIZE
  function automatic logic [5:0] next_idx(logic [5:0] p, logic [2:0] m, logic bwd);
    logic [8:0] t;
    if (bwd) begin
      t = {3'b0, p} + CS4 - {6'b0, m};
    end else begin
      t = {3'b0, p} + {6'b0, m};
    end
    for (int k = 0; k < 4; k++) begin
      if (t >= CS9) t = t - CS9;
    end
    return t[5:0];
  endfunction

  assign lim_raw  = (cfg.max_length == '0) ? 6'd1 : cfg.max_length;
  assign limit    = (lim_raw > CAP6) ? CAP6 : lim_raw;
  assign pop      = (state == S_IDLE) && !q_empty;
  assign rsp_load = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = to_addr(caret);
    mem_wdata = head.load_char;
    mem_raddr = to_addr(head.read_index);
    unique case (state)
      S_IDLE: begin
        if (!q_empty && head.op == wtle_pkg::OP_LOAD && length < limit) begin
          mem_we    = 1'b1;
          mem_waddr = to_addr(length);
        end
      end
      S_OPEN: begin
        if (rp > caret) mem_raddr = to_addr(rp - 6'd1);
        mem_we    = pend;
        mem_waddr = to_addr(wa);
        mem_wdata = rd_data;
      end
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = to_addr(caret);
        mem_wdata = wtle_pkg::CHAR_BLANK;
      end
      S_RD: begin
        mem_raddr = to_addr(caret - 6'd1);
      end
      S_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = to_addr(caret - 6'd1);
        mem_wdata = wtle_pkg::cycle_char(next_idx(pos, cur.mag, cur.op == wtle_pkg::OP_BACK));
      end
      S_CLOSE: begin
        if (rp < length) mem_raddr = to_addr(rp);
        mem_we    = pend;
        mem_waddr = to_addr(wa);
        mem_wdata = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      caret     <= '0;
      comp      <= 1'b0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= head;
            rchar <= '0;
            pend  <= 1'b0;
            unique case (head.op)
              wtle_pkg::OP_FWD, wtle_pkg::OP_BACK: begin
                chg <= 1'b0;
                if (comp) begin
                  state <= S_RD;
                end else if (length < limit) begin
                  rp    <= length;
                  state <= S_OPEN;
                end else begin
                  state <= S_DONE;
                end
              end
              wtle_pkg::OP_LEFT: begin
                chg <= 1'b0;
                if (caret != '0) caret <= caret - 6'd1;
                comp  <= 1'b0;
                state <= S_DONE;
              end
              wtle_pkg::OP_RIGHT: begin
                chg <= 1'b0;
                if (comp) begin
                  comp <= 1'b0;
                end else if (caret < length) begin
                  caret <= caret + 6'd1;
                end
                state <= S_DONE;
              end
              wtle_pkg::OP_BKSP: begin
                chg <= 1'b1;
                if (caret != '0) begin
                  rp    <= caret;
                  state <= S_CLOSE;
                end else begin
                  state <= S_DONE;
                end
              end
              wtle_pkg::OP_DEL: begin
                chg <= 1'b1;
                if (caret < length) begin
                  rp    <= caret + 6'd1;
                  state <= S_CLOSE;
                end else begin
                  state <= S_DONE;
                end
              end
              wtle_pkg::OP_LOAD: begin
                if (length < limit) begin
                  length <= length + 6'd1;
                  caret  <= length + 6'd1;
                  comp   <= 1'b0;
                  chg    <= 1'b1;
                end else begin
                  chg    <= 1'b0;
                end
                state <= S_DONE;
              end
              wtle_pkg::OP_READ: begin
                chg <= 1'b0;
                if (head.read_index < length) begin
                  state <= S_RDCAP;
                end else begin
                  state <= S_DONE;
                end
              end
              wtle_pkg::OP_CLEAR: begin
                length <= '0;
                caret  <= '0;
                comp   <= 1'b0;
                chg    <= 1'b1;
                state  <= S_DONE;
              end
              default: begin
                chg   <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_OPEN: begin
          if (rp > caret) begin
            rp   <= rp - 6'd1;
            wa   <= rp;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) state <= S_BLANK;
          end
        end
        S_BLANK: begin
          length <= length + 6'd1;
          caret  <= caret + 6'd1;
          comp   <= 1'b1;
          state  <= S_RD;
        end
        S_RD: begin
          state <= S_POS;
        end
        S_POS: begin
          pos   <= cycle_pos(rd_data);
          state <= S_STEP;
        end
        S_STEP: begin
          chg   <= 1'b1;
          state <= S_DONE;
        end
        S_CLOSE: begin
          if (rp < length) begin
            rp   <= rp + 6'd1;
            wa   <= rp - 6'd1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              length <= length - 6'd1;
              comp   <= 1'b0;
              if (cur.op == wtle_pkg::OP_BKSP) caret <= caret - 6'd1;
              state  <= S_DONE;
            end
          end
        end
        S_RDCAP: begin
          rchar <= rd_data;
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.changed     <= chg;
            rsp.caret_pos   <= caret;
            rsp.line_length <= length;
            rsp.composing   <= comp;
            rsp.read_char   <= rchar;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/wtle_checker.sv =====
// Port-level checks for the wheel text line editor, bound to the top level.
// Uses wtle_pkg for the payload types and register indexes.
`timescale 1ns / 1ps

module wtle_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input wtle_pkg::out_item_t rsp,
  input logic [3:0]          paddr,
  input logic [31:0]         prdata,
  input logic                pready
);

  // hold a stalled result word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  // drop any pending result on reset
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid just after reset");

  // caret within the line, and a composed character sits left of it
  a_caret: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.caret_pos <= rsp.line_length) &&
                  (!rsp.composing || rsp.caret_pos != 6'd0))
    else $error("caret outside the line");

  // line limit reads back within its six bits
  a_prdata: assert property (@(posedge clk)
    paddr[3:2] == wtle_pkg::REG_MAX_LENGTH |-> prdata[31:6] == 26'b0)
    else $error("line limit read back too wide");

  // no wait states on the configuration port
  a_pready: assert property (@(posedge clk)
    pready)
    else $error("configuration port not ready");

endmodule

bind wheel_text_line_editor wtle_checker u_checker (.*);

// ===== tb/tb_wheel_text_line_editor.sv =====
// Self-checking bench for wheel_text_line_editor: request words go in, and each result
// word is compared with a behavioural copy of the line, the caret and the timestamps.
// Depends on wtle_pkg and the block itself; reads no files.
`timescale 1ns / 1ps

module tb_wheel_text_line_editor;

  localparam int CLK_PERIOD   = 20;
  localparam int DRAIN_CYCLES = 100;   // long enough for the longest wheel insert to finish
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int IDLE_PERCENT = 15;
  localparam int FIRST_WORDS  = 200;
  localparam int PHASE_WORDS  = 270;

  // unused request code at the top of the field
  localparam logic [3:0] REQ_UNUSED_TOP = 4'hF;

  // wheel character ring, first entry in the top byte
  localparam int WHEEL_SIZE = 42;
  localparam logic [8*WHEEL_SIZE-1:0] WHEEL_CHARS =
    " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.'&";

  typedef struct packed {
    wtle_pkg::in_item_t  w;
    logic                typed;   // want holds a fixed answer instead of a prediction
    wtle_pkg::out_item_t want;
  } word_row_t;

  localparam logic                TYPED   = 1'b1;
  localparam logic                PREDICT = 1'b0;
  localparam wtle_pkg::out_item_t NO_WANT = '0;
  // empty line, caret home, nothing composing; with and without a change reported
  localparam wtle_pkg::out_item_t EMPTY_QUIET   = '0;
  localparam wtle_pkg::out_item_t EMPTY_CHANGED = {1'b1, 34'd0};

  // Directed opening: fixed answers only where the line is obviously empty.
  // Reset defaults apply: limit 63, fast gap 6, very fast gap 2, delete gap 20.
  localparam int DIR_ROWS = 25;
  localparam word_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    {wtle_pkg::REQ_READ,  32'd0,        21'd0,      6'd0,  TYPED,   EMPTY_QUIET},
    {wtle_pkg::REQ_LEFT,  32'd0,        21'd0,      6'd0,  TYPED,   EMPTY_QUIET},
    {wtle_pkg::REQ_RIGHT, 32'd0,        21'd0,      6'd0,  TYPED,   EMPTY_QUIET},
    {wtle_pkg::REQ_BKSP,  32'd5,        21'd0,      6'd0,  TYPED,   EMPTY_QUIET},
    {wtle_pkg::REQ_DEL,   32'd20,       21'd0,      6'd0,  TYPED,   EMPTY_CHANGED},
    {wtle_pkg::REQ_FWD,   32'd100,      21'h1FFFFF, 6'h3F, PREDICT, NO_WANT},
    {wtle_pkg::REQ_FWD,   32'd101,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_BACK,  32'd104,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_BACK,  32'd105,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_BACK,  32'd106,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_RIGHT, 32'd106,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_FWD,   32'd300,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_LEFT,  32'd300,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_LOAD,  32'd301,      21'h10FFFF, 6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_LOAD,  32'd302,      21'h1FFFFF, 6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_READ,  32'd303,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_READ,  32'd303,      21'd0,      6'd3,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_READ,  32'd303,      21'd0,      6'h3F, PREDICT, NO_WANT},
    {wtle_pkg::REQ_BKSP,  32'd320,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_DEL,   32'd321,      21'd0,      6'd0,  PREDICT, NO_WANT},
    {REQ_UNUSED_TOP,      32'hFFFFFFFF, 21'h1FFFFF, 6'h3F, PREDICT, NO_WANT},
    {wtle_pkg::REQ_CLEAR, 32'hFFFFFFF0, 21'd0,      6'd0,  TYPED,   EMPTY_CHANGED},
    {wtle_pkg::REQ_FWD,   32'd3,        21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_BKSP,  32'd5,        21'd0,      6'd0,  PREDICT, NO_WANT},
    {wtle_pkg::REQ_READ,  32'd6,        21'd0,      6'd0,  PREDICT, NO_WANT}
  };

  // register settings walked after the opening phase; extremes first
  localparam int SETTING_COUNT = 6;
  localparam int QUIET_SETTING = 0;   // no idling on either side in this phase
  localparam logic [5:0]  MAX_LEN_SET   [SETTING_COUNT] = '{6'd63, 6'd1, 6'd0, 6'd5,
                                                            6'd20, 6'd63};
  localparam logic [15:0] FAST_SET      [SETTING_COUNT] = '{16'hFFFF, 16'd0, 16'd6,
                                                            16'd40, 16'd12, 16'd6};
  localparam logic [15:0] VERY_FAST_SET [SETTING_COUNT] = '{16'hFFFF, 16'd0, 16'd2,
                                                            16'd10, 16'd3, 16'd2};
  localparam logic [15:0] DELETE_SET    [SETTING_COUNT] = '{16'd0, 16'hFFFF, 16'd3,
                                                            16'd30, 16'd8, 16'd20};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  wtle_pkg::in_item_t  req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  wtle_pkg::out_item_t rsp;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  wheel_text_line_editor i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Behavioural copy of the line. Entries past line_len are never read, so the
  // uncleared memory of the block never shows up in a comparison.
  logic [20:0] line_text [0:63];
  int          line_len = 0;
  int          caret = 0;
  bit          composing = 1'b0;
  logic [31:0] wheel_stamp = '0;
  logic [31:0] delete_stamp = '0;
  logic [5:0]  max_len_reg = 6'd63;
  logic [15:0] fast_gap_reg = 16'd6;
  logic [15:0] very_fast_gap_reg = 16'd2;
  logic [15:0] delete_gap_reg = 16'd20;

  word_row_t           request_words [$];   // words still to be offered
  wtle_pkg::out_item_t due_status [$];      // line status awaited, oldest first
  logic                req_typed = 1'b0;
  wtle_pkg::out_item_t req_want = '0;
  logic                quiet_flow = 1'b0;
  logic [31:0]         tick_now = '0;

  int cycle_count = 0;
  int mismatch_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int wheel_steps = 0;
  int full_refusals = 0;
  int deletes_done = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [20:0] wheel_char(int idx);
    return {13'd0, WHEEL_CHARS[8*(WHEEL_SIZE-1-idx) +: 8]};
  endfunction

  // characters outside the ring count as its first entry
  function automatic int wheel_index(logic [20:0] ch);
    for (int i = 0; i < WHEEL_SIZE; i++) begin
      if (wheel_char(i) == ch) return i;
    end
    return 0;
  endfunction

  // zero acts as one; the memory holds at most 63 characters
  function automatic int line_cap();
    int cap;
    cap = (max_len_reg == 6'd0) ? 1 : int'(max_len_reg);
    if (cap > 63) cap = 63;
    return cap;
  endfunction

  task automatic drop_char(input int at);
    for (int i = at; i + 1 < line_len; i++) line_text[i] = line_text[i+1];
    line_len--;
    composing = 1'b0;
    deletes_done++;
  endtask

  // Apply one request to the copy of the line and give the status it leaves.
  task automatic apply_request(input wtle_pkg::in_item_t w,
                               output wtle_pkg::out_item_t status);
    logic [31:0] gap;
    int step;
    int slot;
    int idx;
    status = '0;
    case (w.req_type)
      wtle_pkg::REQ_FWD, wtle_pkg::REQ_BACK: begin
        gap = w.now_tick - wheel_stamp;
        wheel_stamp = w.now_tick;
        step = (gap < very_fast_gap_reg) ? 4 : (gap < fast_gap_reg) ? 2 : 1;
        if (!composing && line_len >= line_cap()) begin
          full_refusals++;
        end else begin
          // open a blank at the caret before the first step
          if (!composing) begin
            for (int i = line_len; i > caret; i--) line_text[i] = line_text[i-1];
            line_text[caret] = wtle_pkg::CHAR_BLANK;
            line_len++;
            caret++;
            composing = 1'b1;
          end
          slot = caret - 1;
          idx = wheel_index(line_text[slot]);
          if (w.req_type == wtle_pkg::REQ_BACK) idx = (idx + 4 * WHEEL_SIZE - step) % WHEEL_SIZE;
          else idx = (idx + step) % WHEEL_SIZE;
          line_text[slot] = wheel_char(idx);
          status.changed = 1'b1;
          wheel_steps++;
        end
      end
      wtle_pkg::REQ_LEFT: begin
        if (caret > 0) caret--;
        composing = 1'b0;
      end
      wtle_pkg::REQ_RIGHT: begin
        if (composing) composing = 1'b0;
        else if (caret < line_len) caret++;
      end
      wtle_pkg::REQ_BKSP, wtle_pkg::REQ_DEL: begin
        gap = w.now_tick - delete_stamp;
        if (gap >= {16'd0, delete_gap_reg}) begin
          if (w.req_type == wtle_pkg::REQ_BKSP) begin
            if (caret > 0) begin
              drop_char(caret - 1);
              caret--;
            end
          end else if (caret < line_len) begin
            drop_char(caret);
          end
          delete_stamp = w.now_tick;
          status.changed = 1'b1;
        end
      end
      wtle_pkg::REQ_LOAD: begin
        if (line_len < line_cap()) begin
          line_text[line_len] = w.load_char;
          line_len++;
          caret = line_len;
          composing = 1'b0;
          status.changed = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      wtle_pkg::REQ_READ: begin
        if (int'(w.read_index) < line_len) status.read_char = line_text[w.read_index];
      end
      wtle_pkg::REQ_CLEAR: begin
        line_len = 0;
        caret = 0;
        composing = 1'b0;
        wheel_stamp = w.now_tick;
        delete_stamp = '0;
        status.changed = 1'b1;
      end
      default: begin
      end
    endcase
    status.caret_pos   = caret[5:0];
    status.line_length = line_len[5:0];
    status.composing   = composing;
  endtask

  // Queue one request word; ticks mostly creep forward so the wheel and delete
  // gaps land on both sides of their thresholds, with the odd jump anywhere.
  task automatic push_word(input logic [3:0] code, input bit jump);
    word_row_t row;
    int pick;
    pick = $urandom_range(0, 99);
    if (jump || pick >= 97) tick_now = $urandom;
    else if (pick < 50) tick_now += $urandom_range(0, 4);
    else if (pick < 80) tick_now += $urandom_range(0, 24);
    else tick_now += $urandom_range(0, 400);
    row = '0;
    row.w.req_type  = code;
    row.w.now_tick  = tick_now;
    row.w.load_char = $urandom_range(0, 1) ? 21'($urandom_range(32'h20, 32'h7E))
                                           : 21'($urandom);
    row.w.read_index = $urandom_range(0, 1) ? 6'($urandom_range(0, 7))
                                            : 6'($urandom);
    row.typed = PREDICT;
    request_words.push_back(row);
  endtask

  // Mostly well-formed editing: wheel bursts, often closed by a caret move, loads,
  // caret walks, delete runs, reads; a little noise and a rare clear on top.
  task automatic plan_random(input int count);
    int made;
    int pick;
    int burst;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        burst = $urandom_range(1, 6);
        repeat (burst) push_word($urandom_range(0, 1) ? wtle_pkg::REQ_BACK
                                                      : wtle_pkg::REQ_FWD, 1'b0);
        made += burst;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          push_word(wtle_pkg::REQ_RIGHT, 1'b0);
          made++;
        end else if (pick < 7) begin
          push_word(wtle_pkg::REQ_LEFT, 1'b0);
          made++;
        end
      end else if (pick < 54) begin
        burst = $urandom_range(1, 4);
        repeat (burst) push_word(wtle_pkg::REQ_LOAD, 1'b0);
        made += burst;
      end else if (pick < 66) begin
        burst = $urandom_range(1, 4);
        repeat (burst) push_word($urandom_range(0, 1) ? wtle_pkg::REQ_RIGHT
                                                      : wtle_pkg::REQ_LEFT, 1'b0);
        made += burst;
      end else if (pick < 80) begin
        burst = $urandom_range(1, 3);
        repeat (burst) push_word($urandom_range(0, 1) ? wtle_pkg::REQ_DEL
                                                      : wtle_pkg::REQ_BKSP, 1'b0);
        made += burst;
      end else if (pick < 91) begin
        push_word(wtle_pkg::REQ_READ, 1'b0);
        made++;
      end else if (pick < 93) begin
        push_word(wtle_pkg::REQ_CLEAR, 1'b0);
        made++;
      end else if (pick < 96) begin
        push_word(4'($urandom_range(wtle_pkg::REQ_CLEAR + 1, REQ_UNUSED_TOP)), 1'b0);
        made++;
      end else begin
        push_word(4'($urandom_range(0, REQ_UNUSED_TOP)), 1'b1);
        made++;
      end
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where psel, penable, pwrite and pready are all high.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    readback = (idx == wtle_pkg::REG_MAX_LENGTH) ? {26'd0, value[5:0]}
                                                 : {16'd0, value[15:0]};
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      wtle_pkg::REG_MAX_LENGTH:    max_len_reg       = value[5:0];
      wtle_pkg::REG_FAST_GAP:      fast_gap_reg      = value[15:0];
      wtle_pkg::REG_VERY_FAST_GAP: very_fast_gap_reg = value[15:0];
      wtle_pkg::REG_DELETE_GAP:    delete_gap_reg    = value[15:0];
      default: begin
      end
    endcase
    // the address still points at the register, so it reads back its new value
    @(negedge clk);
    if (prdata !== readback) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("[%0t] register %0d read back %h, expected %h",
                 $realtime, idx, prdata, readback);
    end
  endtask

  // Hold the sender until every awaited word is back, then let the block go quiet.
  task automatic settle();
    do @(posedge clk); while (request_words.size() != 0 || req_valid || due_status.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: predict on acceptance, then offer the next word or idle.
  always @(posedge clk) begin : feed_requests
    wtle_pkg::out_item_t predicted;
    word_row_t row;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        apply_request(req, predicted);
        due_status.push_back(req_typed ? req_want : predicted);
        words_sent++;
      end
      // a stalled word stays put; otherwise advance or drop valid
      if (!req_valid || !req_stall) begin
        if (request_words.size() != 0 &&
            (quiet_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          row = request_words.pop_front();
          req       <= row.w;
          req_typed <= row.typed;
          req_want  <= row.want;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, switched off during the quiet phase
  always @(posedge clk) begin
    rsp_stall <= !quiet_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Compare every accepted result word with the oldest awaited status.
  always @(posedge clk) begin : check_results
    wtle_pkg::out_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("[%0t] result word with nothing awaited: %h", $realtime, rsp);
      end else begin
        want = due_status.pop_front();
        results_checked++;
        if (rsp.changed !== want.changed || rsp.caret_pos !== want.caret_pos ||
            rsp.line_length !== want.line_length || rsp.composing !== want.composing ||
            rsp.read_char !== want.read_char) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $write("[%0t] result %0d exp/got: changed %0d/%0d caret %0d/%0d ",
                   $realtime, results_checked, want.changed, rsp.changed,
                   want.caret_pos, rsp.caret_pos);
            $display("length %0d/%0d composing %0d/%0d char %h/%h",
                     want.line_length, rsp.line_length,
                     want.composing, rsp.composing, want.read_char, rsp.read_char);
          end
        end
      end
    end
  end

  // Watchdog: drop the run if it has hung
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d words still awaited",
               cycle_count, due_status.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : run
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: directed rows first, then random editing
    for (int r = 0; r < DIR_ROWS; r++) request_words.push_back(DIRECTED_ROWS[r]);
    plan_random(FIRST_WORDS);
    settle();

    // walk the register settings; the line carries over, so a lowered limit
    // meets a longer line
    for (int s = 0; s < SETTING_COUNT; s++) begin
      write_reg(wtle_pkg::REG_MAX_LENGTH,    {26'd0, MAX_LEN_SET[s]});
      write_reg(wtle_pkg::REG_FAST_GAP,      {16'd0, FAST_SET[s]});
      write_reg(wtle_pkg::REG_VERY_FAST_GAP, {16'd0, VERY_FAST_SET[s]});
      write_reg(wtle_pkg::REG_DELETE_GAP,    {16'd0, DELETE_SET[s]});
      quiet_flow <= (s == QUIET_SETTING);
      plan_random(PHASE_WORDS);
      settle();
    end
    quiet_flow <= 1'b0;

    $display("covered %0d request words over %0d register settings, %0d results compared",
             words_sent, SETTING_COUNT + 1, results_checked);
    $display("wheel steps %0d, characters removed %0d, refusals on a full line %0d",
             wheel_steps, deletes_done, full_refusals);
    if (mismatch_count == 0 && due_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== wheel_text_line_editor.f =====
src/wtle_pkg.sv
src/wtle_front.sv
src/wtle_queue.sv
src/wtle_back.sv
src/wheel_text_line_editor.sv
src/wtle_checker.sv
tb/tb_wheel_text_line_editor.sv
